[rtl/pn2d_pkg.sv]
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types and constants for the 2D gradient noise sampler.
// ----------------------------------------------------------------------------
package pn2d_pkg;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Gradient codes
	localparam logic [1:0] GRAD_PP = 2'd0; // (1,1)
	localparam logic [1:0] GRAD_NP = 2'd1; // (-1,1)
	localparam logic [1:0] GRAD_NN = 2'd2; // (-1,-1)
	localparam logic [1:0] GRAD_PN = 2'd3; // (1,-1)

	function automatic logic grad_x_neg(input logic [1:0] code);
		grad_x_neg = (code == GRAD_NP) || (code == GRAD_NN);
	endfunction

	function automatic logic grad_y_neg(input logic [1:0] code);
		grad_y_neg = (code == GRAD_NN) || (code == GRAD_PN);
	endfunction

endpackage

[rtl/pn2d_fade.sv]
// ----------------------------------------------------------------------------
// pn2d_fade
// Pipelined quintic fade 6t^5-15t^4+10t^3 in Q16, five register stages.
// ----------------------------------------------------------------------------
module pn2d_fade #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [FRACTION_BITS-1:0] frac,
	output logic [16:0]              fade
);

	localparam int TW = 17;

	logic [TW-1:0] t_s1;
	logic [TW-1:0] t_s2, t2_s2;
	logic [36:0]   p_s2;
	logic [TW-1:0] t3_s3;
	logic [20:0]   p16_s3;
	logic [TW-1:0] t3_s4;
	logic [20:0]   p16_s4;
	logic [37:0]   r_s5;
	logic [33:0]   tt_1;
	logic [40:0]   p32_1;
	logic [33:0]   t3w_2;

	// t^2 and the quadratic term from t
	assign tt_1  = 34'(t_s1) * 34'(t_s1);
	assign p32_1 = 41'(6) * 41'(tt_1) - 41'(15) * (41'(t_s1) << 16) + (41'(10) << 32);
	assign t3w_2 = 34'(t2_s2) * 34'(t_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= TW'(frac) << (16 - FRACTION_BITS);
			t_s2   <= t_s1;
			t2_s2  <= TW'(tt_1 >> 16);
			p_s2   <= p32_1[36:0];
			t3_s3  <= TW'(t3w_2 >> 16);
			p16_s3 <= 21'(p_s2 >> 16);
			t3_s4  <= t3_s3;
			p16_s4 <= p16_s3;
			r_s5   <= 38'(t3_s4) * 38'(p16_s4);
		end
	end

	assign fade = ((r_s5 >> 16) > 38'(65536)) ? 17'd65536 : 17'(r_s5 >> 16);

endmodule

[rtl/perlin_noise_2d_sampler_core.sv]
// A sample word enters at s0 and its result is registered after the corner reads,
// fade pipeline, two lerp multiplies and magnitude; a held output stalls it.
// Throughput: one word per cycle, write or sample, when the output is not held;
// the corner reads use four gradient table copies, one write and one read port each.
// Reset clears only valid bits; the gradient table is undefined until written.
// ----------------------------------------------------------------------------
// perlin_noise_2d_sampler_core
// Streaming 2D gradient noise sampler with a writable gradient grid.
// ----------------------------------------------------------------------------
module perlin_noise_2d_sampler_core #(
	parameter int GRID_CELLS    = 256,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: x_coord[15:0], y_coord[31:16], cell_x[39:32], cell_y[47:40],
	//        gradient_code[49:48], zero fill [55:50]
	input  logic [55:0] s_tdata,
	// tuser: action (0 write, 1 sample)
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: noise_magnitude[15:0]
	output logic [15:0] m_tdata
);

	localparam int CB    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int DEPTH = GRID_CELLS * GRID_CELLS;
	localparam int AB    = $clog2(DEPTH);
	localparam int NS    = 8;           // pipeline depth
	localparam int DW    = FRACTION_BITS + 3; // dot product width, spans +-2^(F+1)
	localparam int LW    = DW + 18;     // first lerp width
	localparam int VW    = LW + 18;     // second lerp width

	// Bias that makes any integer part non-negative, and the reciprocal used
	// to wrap it when the grid is not a power of two
	localparam longint WRAP_OFF = longint'(GRID_CELLS) *
		((longint'(1) << (16 - FRACTION_BITS)) / longint'(GRID_CELLS) + 1);
	localparam longint WRAP_RCP = ((longint'(1) << 32) + longint'(GRID_CELLS) - 1) /
		longint'(GRID_CELLS);

	// Pipeline moves whenever the output slot is free or being taken
	logic adv;
	logic [NS:1] vld;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic             acc;
	logic             act;
	logic signed [15:0] xin, yin;
	logic [7:0]       cx, cy;
	logic [1:0]       gcode;
	assign acc   = s_tvalid && s_tready;
	assign act   = s_tuser;
	assign xin   = s_tdata[15:0];
	assign yin   = s_tdata[31:16];
	assign cx    = s_tdata[39:32];
	assign cy    = s_tdata[47:40];
	assign gcode = s_tdata[49:48];

	// Cell index: floor of coordinate, wrapped by grid size
	logic signed [16-FRACTION_BITS:0] ipx, ipy;
	logic [CB-1:0] x0, y0, x1, y1;
	assign ipx = (16 - FRACTION_BITS + 1)'(xin >>> FRACTION_BITS);
	assign ipy = (16 - FRACTION_BITS + 1)'(yin >>> FRACTION_BITS);

	function automatic logic [CB-1:0] wrap(input logic signed [16-FRACTION_BITS:0] v);
		logic [15:0] u;
		logic [47:0] prod;
		logic [15:0] q;
		if ((GRID_CELLS & (GRID_CELLS - 1)) == 0) begin
			// power of two: low bits of the two's complement value
			wrap = CB'(v);
		end else begin
			// biased value minus quotient times grid, quotient by reciprocal
			u    = 16'(longint'(v) + WRAP_OFF);
			prod = 48'(u) * 48'(WRAP_RCP);
			q    = 16'(prod >> 32);
			wrap = CB'(u - 16'(longint'(q) * GRID_CELLS));
		end
	endfunction

	function automatic logic [CB-1:0] inc(input logic [CB-1:0] v);
		inc = (32'(v) == GRID_CELLS - 1) ? '0 : CB'(32'(v) + 1);
	endfunction

	function automatic logic [AB-1:0] cell_addr(input logic [CB-1:0] ax,
		input logic [CB-1:0] ay);
		cell_addr = AB'(32'(ax) * GRID_CELLS + 32'(ay));
	endfunction

	assign x0 = wrap(ipx);
	assign y0 = wrap(ipy);
	assign x1 = inc(x0);
	assign y1 = inc(y0);

	logic wr_en;
	logic [AB-1:0] wr_addr;
	assign wr_en   = acc && (act == pn2d_pkg::ACT_WRITE) &&
	                 (32'(cx) < GRID_CELLS) && (32'(cy) < GRID_CELLS);
	assign wr_addr = AB'(32'(cx) * GRID_CELLS + 32'(cy));

	// Four table copies, one per corner read
	logic [1:0] mem00 [DEPTH];
	logic [1:0] mem10 [DEPTH];
	logic [1:0] mem01 [DEPTH];
	logic [1:0] mem11 [DEPTH];
	logic [1:0] g00_s1, g10_s1, g01_s1, g11_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem00[wr_addr] <= gcode;
			mem10[wr_addr] <= gcode;
			mem01[wr_addr] <= gcode;
			mem11[wr_addr] <= gcode;
		end
		if (adv) begin
			g00_s1 <= mem00[cell_addr(x0, y0)];
			g10_s1 <= mem10[cell_addr(x1, y0)];
			g01_s1 <= mem01[cell_addr(x0, y1)];
			g11_s1 <= mem11[cell_addr(x1, y1)];
		end
	end

	// Valid chain; only samples produce results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[NS-1:1], acc && (act == pn2d_pkg::ACT_SAMPLE)};
		end
	end

	logic [FRACTION_BITS-1:0] fx_s1, fy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s1 <= xin[FRACTION_BITS-1:0];
			fy_s1 <= yin[FRACTION_BITS-1:0];
		end
	end

	// Fade units start from the registered fraction
	logic [16:0] wx, wy;
	pn2d_fade #(.FRACTION_BITS(FRACTION_BITS)) u_fade_x (
		.clk(clk), .en(adv), .frac(fx_s1), .fade(wx));
	pn2d_fade #(.FRACTION_BITS(FRACTION_BITS)) u_fade_y (
		.clk(clk), .en(adv), .frac(fy_s1), .fade(wy));

	// Corner dot products in stage 2
	function automatic logic signed [DW-1:0] dotp(input logic [1:0] c,
		input logic signed [DW-1:0] ox, input logic signed [DW-1:0] oy);
		logic signed [DW-1:0] a, b;
		a = pn2d_pkg::grad_x_neg(c) ? -ox : ox;
		b = pn2d_pkg::grad_y_neg(c) ? -oy : oy;
		dotp = a + b;
	endfunction

	logic signed [DW-1:0] ox0, oy0, ox1, oy1;
	assign ox0 = DW'($signed({1'b0, fx_s1}));
	assign oy0 = DW'($signed({1'b0, fy_s1}));
	assign ox1 = ox0 - DW'(1 << FRACTION_BITS);
	assign oy1 = oy0 - DW'(1 << FRACTION_BITS);

	// n values are delayed to meet fade output (fade ready after s6)
	logic signed [DW-1:0] n00_d [2:6], n10_d [2:6], n01_d [2:6], n11_d [2:6];
	always_ff @(posedge clk) begin
		if (adv) begin
			n00_d[2] <= dotp(g00_s1, ox0, oy0);
			n10_d[2] <= dotp(g10_s1, ox1, oy0);
			n01_d[2] <= dotp(g01_s1, ox0, oy1);
			n11_d[2] <= dotp(g11_s1, ox1, oy1);
			for (int i = 3; i <= 6; i++) begin
				n00_d[i] <= n00_d[i-1];
				n10_d[i] <= n10_d[i-1];
				n01_d[i] <= n01_d[i-1];
				n11_d[i] <= n11_d[i-1];
			end
		end
	end

	// Stage 7: first lerp along x; carry wy along
	logic signed [LW-1:0] ix0_s7, ix1_s7;
	logic [16:0]          wy_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			ix0_s7 <= (LW'(n00_d[6]) <<< 16) +
			          $signed({1'b0, wx}) * (LW'(n10_d[6]) - LW'(n00_d[6]));
			ix1_s7 <= (LW'(n01_d[6]) <<< 16) +
			          $signed({1'b0, wx}) * (LW'(n11_d[6]) - LW'(n01_d[6]));
			wy_s7  <= wy;
		end
	end

	// Fade for y is ready with wx at s6; wy_s7 holds the value that
	// matches ix*_s7, since both fades share timing and wy was registered here
	logic signed [VW-1:0] val;
	logic [VW-1:0]        mag;
	logic [VW-1:0]        shf;
	assign val = (VW'(ix0_s7) <<< 16) + $signed({1'b0, wy_s7}) * VW'(ix1_s7 - ix0_s7);
	assign mag = val[VW-1] ? VW'(-val) : VW'(val);
	assign shf = mag >> (FRACTION_BITS + 17);

	// Stage 8: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= (shf > VW'(65535)) ? 16'hFFFF : shf[15:0];
		end
	end
	assign m_tvalid = vld[NS];

endmodule
